// ===== hdl/lidar_point_camera_projection_assert.svh =====
// Assertion macros for the lidar point camera projection block.
// Used by the top level only; needs nothing else.
`ifndef LIDAR_POINT_CAMERA_PROJECTION_ASSERT_SVH
`define LIDAR_POINT_CAMERA_PROJECTION_ASSERT_SVH

// condition in the same cycle
`define LPCP_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("lpcp assertion failed");

// condition in the next cycle
`define LPCP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("lpcp assertion failed");

`endif

// ===== hdl/lpcp_pkg.sv =====
// Shared types, constants and helper functions of the lidar camera projection.
// No dependencies.
package lpcp_pkg;

    localparam int COORD_W       = 32;
    localparam int COEF_W        = 32;
    localparam int NUM_CAMS      = 4;
    localparam int CAM_W         = 2;
    localparam int MAT_ROWS      = 3;
    localparam int ROW_TERMS     = 4;
    localparam int CAM_COEFS     = MAT_ROWS * ROW_TERMS;
    localparam int TABLE_DEPTH   = NUM_CAMS * CAM_COEFS;
    localparam int IDX_W         = 6;
    localparam int SLOT_W        = 4;
    localparam int REG_IDX_W     = 3;
    localparam int PROD_W        = 64;
    localparam int SUM_W         = 66;
    localparam int NUM_W         = 68;
    localparam int DEN_W         = 67;

    localparam int DEF_POINT_FRAC_BITS  = 16;
    localparam int DEF_PIXEL_COORD_BITS = 12;
    localparam int DEF_COLS             = 640;
    localparam int DEF_ROWS             = 480;

    typedef enum logic [0:0] {
        OP_LOAD    = 1'b0,
        OP_PROJECT = 1'b1
    } op_t;

    typedef enum logic [CAM_W-1:0] {
        CAM0 = 2'd0,
        CAM1 = 2'd1,
        CAM2 = 2'd2,
        CAM3 = 2'd3
    } cam_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CAM0_COLS = 3'd0,
        REG_CAM0_ROWS = 3'd1,
        REG_CAM1_COLS = 3'd2,
        REG_CAM1_ROWS = 3'd3,
        REG_CAM2_COLS = 3'd4,
        REG_CAM2_ROWS = 3'd5,
        REG_CAM3_COLS = 3'd6,
        REG_CAM3_ROWS = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        cam_t                      cam;
    } point_t;

    typedef struct packed {
        point_t                  point;
        logic signed [NUM_W-1:0] n_u;
        logic signed [NUM_W-1:0] n_v;
        logic [DEN_W-1:0]        d;
        logic                    w_zero;
    } ratio_t;

    typedef struct packed {
        logic              hit;
        logic [CAM_W-1:0]  cam;
        logic [SLOT_W-1:0] slot;
    } coef_slot_t;

    function automatic cam_t quadrant(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y);
        logic xp;
        logic xn;
        logic yp;
        logic yn;
        cam_t c;
        xp = !x[COORD_W-1] && (x != '0);
        xn = x[COORD_W-1];
        yp = !y[COORD_W-1] && (y != '0);
        yn = y[COORD_W-1];
        priority if (xp && yp) c = CAM0;
        else if (xn && yp)     c = CAM1;
        else if (xn && yn)     c = CAM2;
        else                   c = CAM3;
        return c;
    endfunction

    function automatic coef_slot_t decode_slot(input logic [IDX_W-1:0] idx);
        coef_slot_t s;
        s.hit  = idx < IDX_W'(TABLE_DEPTH);
        s.cam  = '0;
        s.slot = SLOT_W'(idx);
        for (int c = 1; c < NUM_CAMS; c++) begin
            if (idx >= IDX_W'(c * CAM_COEFS))
            begin
                s.cam  = CAM_W'(c);
                s.slot = SLOT_W'(idx - IDX_W'(c * CAM_COEFS));
            end
        end
        return s;
    endfunction

endpackage

// ===== hdl/lpcp_point_if.sv =====
// Input request channel: coefficient loads and points.
// Depends on lpcp_pkg.
interface lpcp_point_if
    import lpcp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [IDX_W-1:0]          coef_index;
    logic signed [COEF_W-1:0]  coef_value;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;

    modport source (output valid, op, coef_index, coef_value, point_x, point_y, point_z,
                    input ready);
    modport sink (input valid, op, coef_index, coef_value, point_x, point_y, point_z,
                  output ready);
endinterface

// ===== hdl/lpcp_result_if.sv =====
// Result channel: projected point with camera, pixel and in-view flag.
// Depends on lpcp_pkg.
interface lpcp_result_if
    import lpcp_pkg::*;
#(
    parameter int PIXEL_COORD_BITS = DEF_PIXEL_COORD_BITS
)
();
    logic                        valid;
    logic                        ready;
    logic signed [COORD_W-1:0]   out_x;
    logic signed [COORD_W-1:0]   out_y;
    logic signed [COORD_W-1:0]   out_z;
    logic [CAM_W-1:0]            camera;
    logic                        in_view;
    logic [PIXEL_COORD_BITS-1:0] pixel_col;
    logic [PIXEL_COORD_BITS-1:0] pixel_row;

    modport source (output valid, out_x, out_y, out_z, camera, in_view, pixel_col, pixel_row,
                    input ready);
    modport sink (input valid, out_x, out_y, out_z, camera, in_view, pixel_col, pixel_row,
                  output ready);
endinterface

// ===== hdl/lpcp_cfg_if.sv =====
// Configuration write channel: register index and data.
// Depends on lpcp_pkg.
interface lpcp_cfg_if
    import lpcp_pkg::*;
#(
    parameter int PIXEL_COORD_BITS = DEF_PIXEL_COORD_BITS
)
();
    logic                        valid;
    logic                        ready;
    logic [REG_IDX_W-1:0]        index;
    logic [PIXEL_COORD_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/lpcp_ram.sv =====
// Generic single write port RAM with registered read.
// No dependencies.
module lpcp_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hdl/lpcp_front.sv =====
// Coefficient table (one RAM per matrix slot, addressed by camera), table read
// stage and product stage. Depends on lpcp_pkg and lpcp_ram.
module lpcp_front
    import lpcp_pkg::*;
#(
    parameter int POINT_FRAC_BITS = DEF_POINT_FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_op,
    input  logic [IDX_W-1:0]         in_idx,
    input  logic signed [COEF_W-1:0] in_coef,
    input  point_t                   in_point,
    output logic                     out_valid,
    input  logic                     out_ready,
    output point_t                   out_point,
    output logic signed [PROD_W-1:0] out_prod [CAM_COEFS]
);
    localparam int NST = 2;

    logic [NST-1:0]           valid_reg;
    logic [NST:0]             en;
    point_t                   s1_point_reg;
    point_t                   s2_point_reg;
    logic signed [COEF_W-1:0] coef_rd [CAM_COEFS];
    logic signed [PROD_W-1:0] term [CAM_COEFS];
    logic signed [PROD_W-1:0] prod_reg [CAM_COEFS];
    coef_slot_t               slot;
    logic                     load;

    always_comb
    begin
        en[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];
    assign slot     = decode_slot(in_idx);
    assign load     = in_valid && en[0] && (op_t'(in_op) == OP_LOAD) && slot.hit;

    for (genvar k = 0; k < CAM_COEFS; k++)
    begin : g_term
        localparam int COL = k % ROW_TERMS;

        lpcp_ram #(.WIDTH(COEF_W), .DEPTH(NUM_CAMS)) u_ram
        (
            .clk   (clk),
            .we    (load && (slot.slot == SLOT_W'(k))),
            .waddr (slot.cam),
            .wdata (in_coef),
            .re    (en[0]),
            .raddr (in_point.cam),
            .rdata (coef_rd[k])
        );

        if (COL == 0)
        begin : g_x
            assign term[k] = coef_rd[k] * $signed(s1_point_reg.x);
        end
        else if (COL == 1)
        begin : g_y
            assign term[k] = coef_rd[k] * $signed(s1_point_reg.y);
        end
        else if (COL == 2)
        begin : g_z
            assign term[k] = coef_rd[k] * $signed(s1_point_reg.z);
        end
        else
        begin : g_t
            assign term[k] = PROD_W'(coef_rd[k]) <<< POINT_FRAC_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid && (op_t'(in_op) == OP_PROJECT);
            end
            if (en[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_point_reg <= in_point;
        end
        if (en[1])
        begin
            s2_point_reg <= s1_point_reg;
            prod_reg     <= term;
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_point = s2_point_reg;
    assign out_prod  = prod_reg;
endmodule

// ===== hdl/lpcp_accum.sv =====
// Row sums of the projection (two adder stages), |w|, and the rounding
// numerators and denominator. Depends on lpcp_pkg.
module lpcp_accum
    import lpcp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  point_t                   in_point,
    input  logic signed [PROD_W-1:0] in_prod [CAM_COEFS],
    output logic                     out_valid,
    input  logic                     out_ready,
    output ratio_t                   out_ratio
);
    localparam int NST    = 4;
    localparam int PAIR_W = PROD_W + 1;

    logic [NST-1:0]           valid_reg;
    logic [NST:0]             en;
    point_t                   point_reg [NST-1];
    logic signed [PAIR_W-1:0] pair_reg [MAT_ROWS][2];
    logic signed [SUM_W-1:0]  sum_reg [MAT_ROWS];
    logic signed [SUM_W-1:0]  u_reg;
    logic signed [SUM_W-1:0]  v_reg;
    logic [SUM_W-1:0]         aw_reg;
    logic                     wz_reg;
    ratio_t                   ratio_reg;
    logic signed [SUM_W-1:0]  w;

    always_comb
    begin
        en[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];
    assign w        = sum_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            point_reg[0] <= in_point;
            for (int r = 0; r < MAT_ROWS; r++)
            begin
                pair_reg[r][0] <= PAIR_W'(in_prod[r*ROW_TERMS])
                                + PAIR_W'(in_prod[r*ROW_TERMS+1]);
                pair_reg[r][1] <= PAIR_W'(in_prod[r*ROW_TERMS+2])
                                + PAIR_W'(in_prod[r*ROW_TERMS+3]);
            end
        end
        if (en[1])
        begin
            point_reg[1] <= point_reg[0];
            for (int r = 0; r < MAT_ROWS; r++)
            begin
                sum_reg[r] <= SUM_W'(pair_reg[r][0]) + SUM_W'(pair_reg[r][1]);
            end
        end
        if (en[2])
        begin
            point_reg[2] <= point_reg[1];
            u_reg        <= sum_reg[0];
            v_reg        <= sum_reg[1];
            aw_reg       <= w[SUM_W-1] ? unsigned'(-w) : unsigned'(w);
            wz_reg       <= (w == '0);
        end
        if (en[3])
        begin
            ratio_reg.point  <= point_reg[2];
            ratio_reg.n_u    <= (NUM_W'(u_reg) <<< 1) + $signed(NUM_W'(aw_reg));
            ratio_reg.n_v    <= (NUM_W'(v_reg) <<< 1) + $signed(NUM_W'(aw_reg));
            ratio_reg.d      <= DEN_W'(aw_reg) << 1;
            ratio_reg.w_zero <= wz_reg;
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_ratio = ratio_reg;
endmodule

// ===== hdl/lpcp_div.sv =====
// Range check and restoring division pipeline, one quotient bit per stage,
// for column and row in parallel. Depends on lpcp_pkg.
module lpcp_div
    import lpcp_pkg::*;
#(
    parameter int PIXEL_COORD_BITS = DEF_PIXEL_COORD_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ratio_t                      in_ratio,
    output logic                        out_valid,
    input  logic                        out_ready,
    output point_t                      out_point,
    output logic                        out_ok,
    output logic [PIXEL_COORD_BITS-1:0] out_col,
    output logic [PIXEL_COORD_BITS-1:0] out_row
);
    localparam int NST   = PIXEL_COORD_BITS + 1;
    localparam int EXT_W = DEN_W + PIXEL_COORD_BITS;

    typedef struct packed {
        point_t                      point;
        logic                        ok;
        logic [DEN_W-1:0]            d;
        logic [DEN_W-1:0]            rem_u;
        logic [DEN_W-1:0]            rem_v;
        logic [PIXEL_COORD_BITS-1:0] q_u;
        logic [PIXEL_COORD_BITS-1:0] q_v;
    } div_t;

    logic [NST-1:0] valid_reg;
    logic [NST:0]   en;
    div_t           stage_reg [NST];
    div_t           nxt [NST];
    logic [EXT_W-1:0] lim;

    always_comb
    begin
        en[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];
    assign lim      = EXT_W'(in_ratio.d) << PIXEL_COORD_BITS;

    // negative numerators and quotients past the pixel range are out of view
    always_comb
    begin
        nxt[0].point = in_ratio.point;
        nxt[0].ok    = !in_ratio.w_zero
                    && !in_ratio.n_u[NUM_W-1] && !in_ratio.n_v[NUM_W-1]
                    && (EXT_W'(in_ratio.n_u[DEN_W-1:0]) < lim)
                    && (EXT_W'(in_ratio.n_v[DEN_W-1:0]) < lim);
        nxt[0].d     = in_ratio.d;
        nxt[0].rem_u = in_ratio.n_u[DEN_W-1:0];
        nxt[0].rem_v = in_ratio.n_v[DEN_W-1:0];
        nxt[0].q_u   = '0;
        nxt[0].q_v   = '0;
    end

    for (genvar i = 1; i < NST; i++)
    begin : g_step
        localparam int B = PIXEL_COORD_BITS - i;
        logic [EXT_W-1:0] t;
        logic [EXT_W-1:0] ru;
        logic [EXT_W-1:0] rv;

        assign t  = EXT_W'(stage_reg[i-1].d) << B;
        assign ru = EXT_W'(stage_reg[i-1].rem_u);
        assign rv = EXT_W'(stage_reg[i-1].rem_v);

        always_comb
        begin
            nxt[i] = stage_reg[i-1];
            if (ru >= t)
            begin
                nxt[i].rem_u  = DEN_W'(ru - t);
                nxt[i].q_u[B] = 1'b1;
            end
            if (rv >= t)
            begin
                nxt[i].rem_v  = DEN_W'(rv - t);
                nxt[i].q_v[B] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NST; i++)
        begin
            if (en[i])
            begin
                stage_reg[i] <= nxt[i];
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_point = stage_reg[NST-1].point;
    assign out_ok    = stage_reg[NST-1].ok;
    assign out_col   = stage_reg[NST-1].q_u;
    assign out_row   = stage_reg[NST-1].q_v;
endmodule

// ===== hdl/lidar_point_camera_projection.sv =====
// Lidar point to camera pixel projection, top level.
// Pipeline: two table and product stages, four sum stages, one range check, one
// divider stage per pixel bit and the output register. Throughput: one request per
// cycle, loads and points alike, unless the receiver stalls; a load gives no result.
// Reset clears all valid bits and sets every camera to 640 x 480; the coefficient
// table holds no defined value until loaded. Depends on lpcp_pkg and all lpcp_ modules.
`include "lidar_point_camera_projection_assert.svh"

module lidar_point_camera_projection
    import lpcp_pkg::*;
#(
    parameter int POINT_FRAC_BITS  = DEF_POINT_FRAC_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    lpcp_point_if.sink    points,
    lpcp_result_if.source results,
    lpcp_cfg_if.sink      cfg
);
    localparam int PIXEL_COORD_BITS = DEF_PIXEL_COORD_BITS;

    logic                        fr_valid;
    logic                        fr_ready;
    point_t                      fr_point;
    logic signed [PROD_W-1:0]    fr_prod [CAM_COEFS];
    logic                        ac_valid;
    logic                        ac_ready;
    ratio_t                      ac_ratio;
    logic                        dv_valid;
    logic                        dv_ready;
    point_t                      dv_point;
    logic                        dv_ok;
    logic [PIXEL_COORD_BITS-1:0] dv_col;
    logic [PIXEL_COORD_BITS-1:0] dv_row;
    logic [PIXEL_COORD_BITS-1:0] cols_reg [NUM_CAMS];
    logic [PIXEL_COORD_BITS-1:0] rows_reg [NUM_CAMS];
    logic                        out_valid_reg;
    point_t                      out_point_reg;
    logic                        in_view_reg;
    logic [PIXEL_COORD_BITS-1:0] col_reg;
    logic [PIXEL_COORD_BITS-1:0] row_reg;
    logic                        view_next;
    point_t                      in_point;

    assign in_point.x   = points.point_x;
    assign in_point.y   = points.point_y;
    assign in_point.z   = points.point_z;
    assign in_point.cam = quadrant(points.point_x, points.point_y);

    lpcp_front #(.POINT_FRAC_BITS(POINT_FRAC_BITS)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (points.valid),
        .in_ready  (points.ready),
        .in_op     (points.op),
        .in_idx    (points.coef_index),
        .in_coef   (points.coef_value),
        .in_point  (in_point),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_point (fr_point),
        .out_prod  (fr_prod)
    );

    lpcp_accum u_accum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_point  (fr_point),
        .in_prod   (fr_prod),
        .out_valid (ac_valid),
        .out_ready (ac_ready),
        .out_ratio (ac_ratio)
    );

    lpcp_div #(.PIXEL_COORD_BITS(PIXEL_COORD_BITS)) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ac_valid),
        .in_ready  (ac_ready),
        .in_ratio  (ac_ratio),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_point (dv_point),
        .out_ok    (dv_ok),
        .out_col   (dv_col),
        .out_row   (dv_row)
    );

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CAMS; c++)
            begin
                cols_reg[c] <= PIXEL_COORD_BITS'(DEF_COLS);
                rows_reg[c] <= PIXEL_COORD_BITS'(DEF_ROWS);
            end
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_CAM0_COLS: cols_reg[0] <= cfg.data;
                REG_CAM0_ROWS: rows_reg[0] <= cfg.data;
                REG_CAM1_COLS: cols_reg[1] <= cfg.data;
                REG_CAM1_ROWS: rows_reg[1] <= cfg.data;
                REG_CAM2_COLS: cols_reg[2] <= cfg.data;
                REG_CAM2_ROWS: rows_reg[2] <= cfg.data;
                REG_CAM3_COLS: cols_reg[3] <= cfg.data;
                REG_CAM3_ROWS: rows_reg[3] <= cfg.data;
            endcase
        end
    end

    // output register
    assign dv_ready  = !out_valid_reg || results.ready;
    assign view_next = dv_ok && (dv_col < cols_reg[dv_point.cam])
                    && (dv_row < rows_reg[dv_point.cam]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dv_ready)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready)
        begin
            out_point_reg <= dv_point;
            in_view_reg   <= view_next;
            col_reg       <= view_next ? dv_col : '0;
            row_reg       <= view_next ? dv_row : '0;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.out_x     = out_point_reg.x;
    assign results.out_y     = out_point_reg.y;
    assign results.out_z     = out_point_reg.z;
    assign results.camera    = out_point_reg.cam;
    assign results.in_view   = in_view_reg;
    assign results.pixel_col = col_reg;
    assign results.pixel_row = row_reg;

    `LPCP_ASSERT_IMPLIES(a_pixel_in_frame, clk, rst_n, results.valid && results.in_view, (results.pixel_col < cols_reg[results.camera]) && (results.pixel_row < rows_reg[results.camera]))
    `LPCP_ASSERT_IMPLIES(a_out_of_view_zero, clk, rst_n, results.valid && !results.in_view, (results.pixel_col == '0) && (results.pixel_row == '0))
    `LPCP_ASSERT_IMPLIES(a_quadrant_cam0, clk, rst_n, results.valid && !results.out_x[COORD_W-1] && (results.out_x != '0) && !results.out_y[COORD_W-1] && (results.out_y != '0), results.camera == CAM0)
endmodule

// ===== tb/lpcp_tb_if.sv =====
// Testbench copy point: none; the channel interfaces come from the RTL tree.
// Holds the checker's helper types for the projection testbench.
// Depends on lpcp_pkg.
package lpcp_tb_pkg;
    import lpcp_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        cam_t                      cam;
        logic                      in_view;
        logic [11:0]               col;
        logic [11:0]               row;
    } pixel_hit_t;
endpackage

// ===== tb/lpcp_checker.sv =====
// Watches the request, result and config channels, predicts each projection
// and compares it with the block's result. Depends on lpcp_pkg, lpcp_tb_pkg.
module lpcp_checker
    import lpcp_pkg::*;
    import lpcp_tb_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    lpcp_point_if          points,
    lpcp_result_if         results,
    lpcp_cfg_if            cfg,
    output int             fail_count,
    output int             pending
);
    logic signed [31:0] coef_table [TABLE_DEPTH];
    logic [11:0]        frame_size [8];
    pixel_hit_t         expected_hits [$];
    int                 mismatches;

    function automatic logic signed [127:0] row_dot(int base, logic signed [31:0] x,
                                                    logic signed [31:0] y,
                                                    logic signed [31:0] z);
        logic signed [127:0] s;
        s = 128'(coef_table[base]) * 128'(x);
        s += 128'(coef_table[base + 1]) * 128'(y);
        s += 128'(coef_table[base + 2]) * 128'(z);
        s += 128'(coef_table[base + 3]) <<< 16;
        return s;
    endfunction

    // rounded num/den in [0, limit): returns -1 when outside
    function automatic int round_pixel(logic signed [127:0] num, logic signed [127:0] den,
                                       logic [11:0] limit);
        logic signed [127:0] n;
        logic signed [127:0] q;
        n = 2 * num + den;
        if (n < 0)
            return -1;
        q = n / (2 * den);
        if (q >= 128'(limit))
            return -1;
        return int'(q);
    endfunction

    function automatic pixel_hit_t project_point(logic signed [31:0] x,
                                                 logic signed [31:0] y,
                                                 logic signed [31:0] z);
        pixel_hit_t h;
        logic signed [127:0] u;
        logic signed [127:0] v;
        logic signed [127:0] w;
        int c;
        int r;
        h.x = x;
        h.y = y;
        h.z = z;
        if (x > 0 && y > 0)
            h.cam = CAM0;
        else if (x < 0 && y > 0)
            h.cam = CAM1;
        else if (x < 0 && y < 0)
            h.cam = CAM2;
        else
            h.cam = CAM3;
        u = row_dot(int'(h.cam) * 12, x, y, z);
        v = row_dot(int'(h.cam) * 12 + 4, x, y, z);
        w = row_dot(int'(h.cam) * 12 + 8, x, y, z);
        h.in_view = 0;
        h.col = 0;
        h.row = 0;
        if (w != 0)
        begin
            if (w < 0)
                w = -w;
            c = round_pixel(u, w, frame_size[2 * int'(h.cam)]);
            r = round_pixel(v, w, frame_size[2 * int'(h.cam) + 1]);
            if (c >= 0 && r >= 0)
            begin
                h.in_view = 1;
                h.col = 12'(c);
                h.row = 12'(r);
            end
        end
        return h;
    endfunction

    assign pending = expected_hits.size();

    always @(posedge clk or negedge rst_n)
    begin
        pixel_hit_t e;
        if (!rst_n)
        begin
            expected_hits.delete();
            fail_count <= 0;
            mismatches = 0;
            for (int i = 0; i < 8; i++)
                frame_size[i] = (i % 2) ? 12'd480 : 12'd640;
            for (int i = 0; i < TABLE_DEPTH; i++)
                coef_table[i] = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result x=%h", results.out_x);
                end
                else
                begin
                    e = expected_hits.pop_front();
                    if (results.out_x !== e.x || results.out_y !== e.y ||
                        results.out_z !== e.z || results.camera !== e.cam ||
                        results.in_view !== e.in_view || results.pixel_col !== e.col ||
                        results.pixel_row !== e.row)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp %h %h %h cam %0d v %0d %0d,%0d",
                                      " got %h %h %h cam %0d v %0d %0d,%0d"},
                                e.x, e.y, e.z, e.cam, e.in_view, e.col, e.row,
                                results.out_x, results.out_y, results.out_z,
                                results.camera, results.in_view,
                                results.pixel_col, results.pixel_row);
                    end
                end
            end
            if (cfg.valid && cfg.ready)
                frame_size[cfg.index] = cfg.data;
            if (points.valid && points.ready)
            begin
                if (points.op == OP_LOAD)
                begin
                    if (points.coef_index < TABLE_DEPTH)
                        coef_table[points.coef_index] = points.coef_value;
                end
                else
                    expected_hits.insert(expected_hits.size(),
                                         project_point(points.point_x, points.point_y,
                                                       points.point_z));
            end
            fail_count <= mismatches;
        end
    end
endmodule

// ===== tb/testbench.sv =====
// Top of the projection testbench: clock, reset, request and config stimulus,
// receiver stalls and verdict. Depends on lpcp_pkg, the lpcp interfaces and lpcp_checker.
module testbench;
    import lpcp_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   long_hold;
    bit   hold_go;

    lpcp_point_if  points ();
    lpcp_result_if results ();
    lpcp_cfg_if    cfg ();

    lidar_point_camera_projection i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (points),
        .results (results),
        .cfg     (cfg)
    );

    lpcp_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .points     (points),
        .results    (results),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        points.valid = 0;
        points.op = OP_LOAD;
        points.coef_index = 0;
        points.coef_value = 0;
        points.point_x = 0;
        points.point_y = 0;
        points.point_z = 0;
        cfg.valid = 0;
        cfg.index = REG_CAM0_COLS;
        cfg.data = 0;
        results.ready = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
    end

    // receiver: stall pattern plus one long hold-off
    always @(posedge clk)
    begin
        int mode;
        mode = $urandom_range(0, 99);
        if (long_hold)
            results.ready <= 0;
        else if (mode < 30)
            results.ready <= 1;
        else
            results.ready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        long_hold = 0;
        wait (hold_go);
        long_hold = 1;
        repeat (200) @(posedge clk);
        long_hold = 0;
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((points.valid && points.ready) || (results.valid && results.ready) ||
            (cfg.valid && cfg.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    int burst_left;

    task automatic send_request(op_t op, int idx, logic [31:0] val,
                                logic [31:0] x, logic [31:0] y, logic [31:0] z);
        if (burst_left == 0)
        begin
            points.valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        points.valid <= 1;
        points.op <= op;
        points.coef_index <= 6'(idx);
        points.coef_value <= val;
        points.point_x <= x;
        points.point_y <= y;
        points.point_z <= z;
        @(posedge clk);
        while (!points.ready)
            @(posedge clk);
    endtask

    task automatic load_coef(int idx, logic [31:0] val);
        send_request(OP_LOAD, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        send_request(OP_PROJECT, $urandom_range(0, 63), $urandom, x, y, z);
    endtask

    task automatic drain;
        points.valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [11:0] val);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    // camera-like matrix: u = f*x/z + cx style with random content
    task automatic load_camera(int cam, int scale);
        for (int i = 0; i < 12; i++)
        begin
            logic [31:0] v;
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1: v = 32'($signed($urandom_range(0, 2 * scale)) - scale);
                default: v = 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            endcase
            if (i == 10)
                v = 32'(1 << 16) | $urandom_range(0, 255);
            load_coef(cam * 12 + i, v);
        end
    endtask

    function automatic logic [31:0] small_coord(int sgn);
        logic [31:0] m;
        m = $urandom_range(1, 1 << 22);
        return sgn < 0 ? -m : (sgn == 0 ? 32'd0 : m);
    endfunction

    initial
    begin
        burst_left = 0;
        hold_go = 0;
        wait (rst_n);
        @(posedge clk);
        // identity-ish cameras so pixel = x, y scaled, w = z
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 12; i++)
                load_coef(c * 12 + i, (i == 0 || i == 5 || i == 10) ? 32'h10000 : 32'd0);
        load_coef(63, 32'hFFFF_FFFF);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_point(32'hFFFF_0000, 32'h0002_0000, 32'h0001_0000);
        send_point(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h0, 32'h0005_0000, 32'h0);
        send_point(32'h0000_8000, 32'h0000_8000, 32'h0001_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h027F_0000, 32'h01DF_0000, 32'h0001_0000);
        send_point(32'h0280_0000, 32'h01DF_0000, 32'h0001_0000);
        send_point(32'h027F_8000, 32'h0001_0000, 32'h0001_0000);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000);
        drain();
        for (int phase = 0; phase < 5; phase++)
        begin
            for (int r = 0; r < 8; r++)
            begin
                logic [11:0] val;
                case (phase)
                    0: val = 12'd1;
                    1: val = 12'd4095;
                    default: val = 12'($urandom_range(1, 4095));
                endcase
                write_reg(reg_idx_t'(r), val);
            end
            cfg.valid <= 0;
            for (int c = 0; c < 4; c++)
                load_camera(c, 1 << (8 + 4 * phase));
            for (int n = 0; n < 260; n++)
            begin
                if (phase == 2 && n == 50)
                    hold_go = 1;
                if ($urandom_range(0, 19) == 0)
                    load_coef($urandom_range(0, 63), $urandom);
                else
                begin
                    int sx;
                    int sy;
                    sx = $urandom_range(0, 8) == 0 ? 0 : ($urandom_range(0, 1) ? 1 : -1);
                    sy = $urandom_range(0, 8) == 0 ? 0 : ($urandom_range(0, 1) ? 1 : -1);
                    if ($urandom_range(0, 9) == 0)
                        send_point($urandom, $urandom, $urandom);
                    else
                        send_point(small_coord(sx), small_coord(sy),
                                   small_coord($urandom_range(0, 1) ? 1 : -1));
                end
            end
            drain();
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
